[rtl/mi4_pkg.sv]
// Shared widths, constants, command and status types for the 4x4 matrix inverse.
package mi4_pkg;

	localparam int ElemW   = 32;  // Q16.16 element
	localparam int IdxW    = 4;   // element position
	localparam int DetMinW = 63;  // threshold register, Q31.32
	localparam int MagW    = 96;  // operand magnitude, three 32-bit limbs
	localparam int AccW    = 132; // exact products and determinant
	localparam int CofW    = 98;  // exact signed 3x3 cofactor
	localparam int QW      = 34;  // quotient bits, top bit flags overflow
	localparam int DivW    = 165; // remainder and shifted divisor
	localparam int DivNumSh = 33; // Q16.16 scaling plus rounding doubling
	localparam int DivDenSh = QW; // divisor doubled, aligned to top quotient bit

	localparam logic [ElemW-1:0]   OneQ16      = 32'h0001_0000;
	localparam logic [ElemW-1:0]   SatPos      = 32'h7FFF_FFFF;
	localparam logic [ElemW-1:0]   SatNeg      = 32'h8000_0000;
	localparam logic [DetMinW-1:0] DetMinReset = 63'd4295;
	localparam logic [IdxW-1:0]    LastIdx     = 4'd15;

	// datapath micro-operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD_ELEM,
		OP_LOAD_COF,
		OP_MUL,
		OP_MOVE,
		OP_ACC,
		OP_STORE_COF,
		OP_STORE_DET,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [IdxW-1:0] sel;   // element address, or result index on emit
		logic [IdxW-1:0] cidx;  // cofactor address
		logic [1:0]      limb;  // magnitude limb for a multiply
		logic            neg;   // subtract on accumulate
		logic            last;  // final result of the run
	} cmd_t;

	typedef struct packed {
		logic sing;
		logic out_free;
	} status_t;

	// index k of a 3-wide minor mapped past the removed line s
	function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] s);
		return (k < s) ? k : k + 2'd1;
	endfunction

	// minor column used in row j by term t of the 3x3 determinant expansion
	function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] j);
		logic [5:0] p;
		case (t)
			3'd0: p = {2'd0, 2'd1, 2'd2};
			3'd1: p = {2'd0, 2'd2, 2'd1};
			3'd2: p = {2'd1, 2'd0, 2'd2};
			3'd3: p = {2'd1, 2'd2, 2'd0};
			3'd4: p = {2'd2, 2'd0, 2'd1};
			default: p = {2'd2, 2'd1, 2'd0};
		endcase
		case (j)
			2'd0: return p[5:4];
			2'd1: return p[3:2];
			default: return p[1:0];
		endcase
	endfunction

	// odd permutations carry a minus sign
	function automatic logic term_neg(input logic [2:0] t);
		return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
	endfunction

endpackage

[rtl/mi4_datapath.sv]
// Datapath: element store, limb multiplier, accumulators, cofactor store, divider, result register.
module mi4_datapath import mi4_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output status_t                 status,
	input  logic                    in_accept,
	input  logic [IdxW-1:0]         elem_index,
	input  logic signed [ElemW-1:0] elem_value,
	input  logic                    cfg_wr_en,
	input  logic [DetMinW-1:0]      cfg_wr_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [IdxW-1:0]         out_index,
	output logic signed [ElemW-1:0] out_value,
	output logic                    singular,
	output logic                    last
);

	logic [ElemW-1:0]       store_q [16];
	logic [CofW-1:0]        cof_q   [16];
	logic [DetMinW-1:0]     det_min_q;
	logic [MagW-1:0]        mag_q;
	logic                   msgn_q;
	logic [2*ElemW-1:0]     pp_q;
	logic                   pp_neg_q;
	logic [1:0]             pp_sh_q;
	logic                   ppv_q;
	logic signed [AccW-1:0] prod_q;
	logic signed [AccW-1:0] acc_q;
	logic [AccW-1:0]        detmag_q;
	logic                   det_neg_q;
	logic                   sing_q;
	logic [DivW-1:0]        rem_q;
	logic [DivW-1:0]        dsh_q;
	logic [QW-1:0]          quo_q;
	logic                   qneg_q;
	logic                   out_valid_q;
	logic [IdxW-1:0]        out_index_q;
	logic [ElemW-1:0]       out_value_q;
	logic                   singular_q;
	logic                   last_q;

	logic [ElemW-1:0]       elem;
	logic [ElemW-1:0]       emag;
	logic [CofW-1:0]        cof_rd;
	logic [CofW-1:0]        cmag;
	logic [AccW-1:0]        pmag;
	logic [ElemW-1:0]       limb_val;
	logic signed [AccW-1:0] pp_ext;
	logic signed [AccW-1:0] acc_add;
	logic [AccW-1:0]        det_abs;
	logic [QW-2:0]          q_low;
	logic [ElemW-1:0]       quo_val;
	logic [ElemW-1:0]       emit_val;
	logic                   emit;

	// operand selection and magnitudes
	always_comb begin
		elem     = store_q[cmd.sel];
		emag     = elem[ElemW-1] ? (~elem + 1'b1) : elem;
		cof_rd   = cof_q[cmd.cidx];
		cmag     = cof_rd[CofW-1] ? (~cof_rd + 1'b1) : cof_rd;
		pmag     = prod_q[AccW-1] ? AccW'(-prod_q) : AccW'(prod_q);
		case (cmd.limb)
			2'd0: limb_val = mag_q[31:0];
			2'd1: limb_val = mag_q[63:32];
			2'd2: limb_val = mag_q[95:64];
			default: limb_val = '0;
		endcase
		pp_ext   = signed'(AccW'(pp_q) << {pp_sh_q, 5'd0});
		acc_add  = cmd.neg ? (acc_q - prod_q) : (acc_q + prod_q);
		det_abs  = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
		emit     = (cmd.op == OP_EMIT);
	end

	// rounded quotient with saturation to Q16.16, or the identity entry when singular
	always_comb begin
		q_low = quo_q[QW-2:0];
		if (qneg_q) begin
			if (quo_q[QW-1] || (q_low >= (QW-1)'(SatNeg)))
				quo_val = SatNeg;
			else
				quo_val = ~quo_q[ElemW-1:0] + 1'b1;
		end else begin
			if (quo_q[QW-1] || (q_low > (QW-1)'(SatPos)))
				quo_val = SatPos;
			else
				quo_val = quo_q[ElemW-1:0];
		end
		if (sing_q)
			emit_val = (cmd.sel[3:2] == cmd.sel[1:0]) ? OneQ16 : '0;
		else
			emit_val = quo_val;
	end

	// control state: threshold, accumulators, flags, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_min_q   <= DetMinReset;
			ppv_q       <= 1'b0;
			acc_q       <= '0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				det_min_q <= cfg_wr_data;
			ppv_q <= (cmd.op == OP_MUL);
			case (cmd.op)
				OP_ACC:       acc_q <= acc_add;
				OP_STORE_COF: acc_q <= '0;
				OP_STORE_DET: begin
					acc_q  <= '0;
					sing_q <= (acc_q == '0) || (det_abs < AccW'({det_min_q, 32'd0}));
				end
				default: ;
			endcase
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers and stores
	always_ff @(posedge clk) begin
		if (in_accept)
			store_q[elem_index] <= elem_value;
		if (ppv_q)
			prod_q <= pp_neg_q ? (prod_q - pp_ext) : (prod_q + pp_ext);
		case (cmd.op)
			OP_LOAD_ELEM: begin
				mag_q  <= MagW'(emag);
				msgn_q <= elem[ElemW-1];
				prod_q <= '0;
			end
			OP_LOAD_COF: begin
				mag_q  <= MagW'(cmag);
				msgn_q <= cof_rd[CofW-1];
				prod_q <= '0;
			end
			OP_MOVE: begin
				mag_q  <= pmag[MagW-1:0];
				msgn_q <= prod_q[AccW-1];
				prod_q <= '0;
			end
			OP_MUL: begin
				pp_q     <= limb_val * emag;
				pp_neg_q <= msgn_q ^ elem[ElemW-1];
				pp_sh_q  <= cmd.limb;
			end
			OP_STORE_COF: cof_q[cmd.cidx] <= acc_q[CofW-1:0];
			OP_STORE_DET: begin
				detmag_q  <= det_abs;
				det_neg_q <= acc_q[AccW-1];
			end
			OP_DIV_INIT: begin
				rem_q  <= (DivW'(mag_q) << DivNumSh) + DivW'(detmag_q);
				dsh_q  <= DivW'(detmag_q) << DivDenSh;
				quo_q  <= '0;
				qneg_q <= msgn_q ^ det_neg_q;
			end
			OP_DIV_STEP: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			OP_EMIT: begin
				out_index_q <= cmd.sel;
				out_value_q <= emit_val;
				singular_q  <= sing_q;
				last_q      <= cmd.last;
			end
			default: ;
		endcase
	end

	assign status.sing     = sing_q;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign singular  = singular_q;
	assign last      = last_q;

	// a new result never overwrites one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || !out_stall))
		else $error("result emitted over a pending result");

	// operand loads never race a pending partial-product accumulate
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD_ELEM || cmd.op == OP_LOAD_COF || cmd.op == OP_MOVE) |-> !ppv_q)
		else $error("operand load while partial product pending");

	// singular results are identity entries only
	a_sing_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && singular_q) |->
			((out_value_q == OneQ16 && out_index_q[3:2] == out_index_q[1:0]) ||
			 (out_value_q == '0 && out_index_q[3:2] != out_index_q[1:0])))
		else $error("singular result is not identity");

endmodule

[rtl/mi4_ctrl.sv]
// Controller: sequences cofactors, determinant, divisions and result emission.
module mi4_ctrl import mi4_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [IdxW-1:0] elem_index,
	output logic            in_stall,
	input  status_t         status,
	output cmd_t            cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD_A, S_MUL1, S_FLUSH1, S_MOVE, S_MUL2, S_FLUSH2, S_ACC, S_STORE,
		S_DLOAD, S_DMUL, S_DFLUSH, S_DACC, S_DSTORE,
		S_QLOAD, S_QINIT, S_QSTEP, S_EMIT
	} state_t;

	localparam logic [1:0] Mul2LastLimb = 2'd1;
	localparam logic [1:0] DetLastLimb  = 2'd2;
	localparam logic [2:0] LastTerm     = 3'd5;
	localparam logic [5:0] LastStep     = 6'(QW - 1);

	state_t     state_q;
	logic [3:0] cof_q;
	logic [2:0] term_q;
	logic [1:0] limb_q;
	logic [3:0] k_q;
	logic [5:0] step_q;
	logic [1:0] rs, cs;

	assign rs       = cof_q[3:2];
	assign cs       = cof_q[1:0];
	assign in_stall = (state_q != S_IDLE);

	// command decode
	always_comb begin
		cmd    = '0;
		cmd.op = OP_NOP;
		case (state_q)
			S_LOAD_A: begin
				cmd.op  = OP_LOAD_ELEM;
				cmd.sel = {skip_idx(2'd0, rs), skip_idx(perm_col(term_q, 2'd0), cs)};
			end
			S_MUL1: begin
				cmd.op  = OP_MUL;
				cmd.sel = {skip_idx(2'd1, rs), skip_idx(perm_col(term_q, 2'd1), cs)};
			end
			S_MOVE: cmd.op = OP_MOVE;
			S_MUL2: begin
				cmd.op   = OP_MUL;
				cmd.limb = limb_q;
				cmd.sel  = {skip_idx(2'd2, rs), skip_idx(perm_col(term_q, 2'd2), cs)};
			end
			S_ACC: begin
				cmd.op  = OP_ACC;
				cmd.neg = term_neg(term_q) ^ rs[0] ^ cs[0];
			end
			S_STORE: begin
				cmd.op   = OP_STORE_COF;
				cmd.cidx = cof_q;
			end
			S_DLOAD: begin
				cmd.op   = OP_LOAD_COF;
				cmd.cidx = {2'b00, k_q[1:0]};
			end
			S_DMUL: begin
				cmd.op   = OP_MUL;
				cmd.limb = limb_q;
				cmd.sel  = {2'b00, k_q[1:0]};
			end
			S_DACC:   cmd.op = OP_ACC;
			S_DSTORE: cmd.op = OP_STORE_DET;
			S_QLOAD: begin
				// inverse (r,c) takes cofactor (c,r)
				cmd.op   = OP_LOAD_COF;
				cmd.cidx = {k_q[1:0], k_q[3:2]};
			end
			S_QINIT: cmd.op = OP_DIV_INIT;
			S_QSTEP: cmd.op = OP_DIV_STEP;
			S_EMIT: begin
				if (status.out_free) begin
					cmd.op   = OP_EMIT;
					cmd.sel  = k_q;
					cmd.last = (k_q == LastIdx);
				end
			end
			default: ;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cof_q   <= '0;
			term_q  <= '0;
			limb_q  <= '0;
			k_q     <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && elem_index == LastIdx) begin
						cof_q   <= '0;
						term_q  <= '0;
						state_q <= S_LOAD_A;
					end
				end
				S_LOAD_A: state_q <= S_MUL1;
				S_MUL1:   state_q <= S_FLUSH1;
				S_FLUSH1: state_q <= S_MOVE;
				S_MOVE: begin
					limb_q  <= '0;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					limb_q <= limb_q + 2'd1;
					if (limb_q == Mul2LastLimb)
						state_q <= S_FLUSH2;
				end
				S_FLUSH2: state_q <= S_ACC;
				S_ACC: begin
					if (term_q == LastTerm) begin
						state_q <= S_STORE;
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= S_LOAD_A;
					end
				end
				S_STORE: begin
					term_q <= '0;
					if (cof_q == LastIdx) begin
						k_q     <= '0;
						state_q <= S_DLOAD;
					end else begin
						cof_q   <= cof_q + 4'd1;
						state_q <= S_LOAD_A;
					end
				end
				S_DLOAD: begin
					limb_q  <= '0;
					state_q <= S_DMUL;
				end
				S_DMUL: begin
					limb_q <= limb_q + 2'd1;
					if (limb_q == DetLastLimb)
						state_q <= S_DFLUSH;
				end
				S_DFLUSH: state_q <= S_DACC;
				S_DACC: begin
					if (k_q[1:0] == 2'd3) begin
						state_q <= S_DSTORE;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= S_DLOAD;
					end
				end
				S_DSTORE: begin
					k_q     <= '0;
					state_q <= S_QLOAD;
				end
				S_QLOAD: state_q <= status.sing ? S_EMIT : S_QINIT;
				S_QINIT: begin
					step_q  <= '0;
					state_q <= S_QSTEP;
				end
				S_QSTEP: begin
					step_q <= step_q + 6'd1;
					if (step_q == LastStep)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (status.out_free) begin
						if (k_q == LastIdx) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= S_QLOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a run starts only on a load to the last position
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !(in_valid && elem_index == LastIdx)) |=> state_q == S_IDLE)
		else $error("run started without final element");

	// the final emit always returns to idle
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT && cmd.last) |=> state_q == S_IDLE)
		else $error("run did not end after final result");

	// the flagged final result carries the last index
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |-> (cmd.op == OP_EMIT && cmd.sel == LastIdx))
		else $error("last flag on wrong result");

endmodule

[rtl/matrix_inverse_4x4.sv]
// 4x4 matrix inverse by the adjugate, signed Q16.16, top level.
// Elements are loaded one request per cycle while the block is idle. A load to position 15
// starts a run and holds in_stall high until the sixteenth result has been handed to the
// output register. The run forms all sixteen exact cofactors on one 32x32 limb multiplier
// (six product terms plus a store per cofactor), then the determinant, then each result
// through a one-bit-per-cycle restoring divider; a singular matrix skips the divisions and
// emits the identity. Output stalls hold the run until the output register is free.
// The user writes the singularity threshold det_min (Q31.32) only while idle; the block
// itself does not enforce this. It resets to 4295.
module matrix_inverse_4x4 import mi4_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [IdxW-1:0]         elem_index,
	input  logic signed [ElemW-1:0] elem_value,
	input  logic                    cfg_wr_en,
	input  logic [DetMinW-1:0]      cfg_wr_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [IdxW-1:0]         out_index,
	output logic signed [ElemW-1:0] out_value,
	output logic                    singular,
	output logic                    last
);

	cmd_t    cmd;
	status_t status;
	logic    in_accept;

	assign in_accept = in_valid && !in_stall;

	mi4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.elem_index (elem_index),
		.in_stall   (in_stall),
		.status     (status),
		.cmd        (cmd)
	);

	mi4_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_accept   (in_accept),
		.elem_index  (elem_index),
		.elem_value  (elem_value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_index   (out_index),
		.out_value   (out_value),
		.singular    (singular),
		.last        (last)
	);

endmodule
